// ===== src/x86pm_pkg.sv =====
// Shared types, byte codes and field encodings for the x86 prefix/ModRM decoder.
// No dependencies; the RTL files refer to this package by scoped names, the bench imports it.
`timescale 1ns / 1ps

package x86pm_pkg;

    localparam int MAX_PREFIXES = 6;
    localparam int PCNT_W       = $clog2(MAX_PREFIXES + 1);
    localparam int NUM_REGS     = 8;
    localparam int NUM_MAPS     = 4;
    localparam int MAP_W        = 64;

    // item kinds carried on s_tuser
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_REGWR = 1'b1;

    // operand / write size codes
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;

    // prefix bytes
    localparam logic [7:0] PFX_ESC   = 8'h0F;
    localparam logic [7:0] PFX_ES    = 8'h26;
    localparam logic [7:0] PFX_CS    = 8'h2E;
    localparam logic [7:0] PFX_SS    = 8'h36;
    localparam logic [7:0] PFX_DS    = 8'h3E;
    localparam logic [7:0] PFX_FS    = 8'h64;
    localparam logic [7:0] PFX_GS    = 8'h65;
    localparam logic [7:0] PFX_OPSZ  = 8'h66;
    localparam logic [7:0] PFX_ADSZ  = 8'h67;
    localparam logic [7:0] PFX_LOCK  = 8'hF0;
    localparam logic [7:0] PFX_REPNE = 8'hF2;
    localparam logic [7:0] PFX_REP   = 8'hF3;

    // mode flag bit positions
    localparam int FLG_LOCK  = 0;
    localparam int FLG_REPNE = 1;
    localparam int FLG_REP   = 2;
    localparam int FLG_ADSZ  = 3;
    localparam int FLG_OPSZ  = 4;

    // ModRM mod values
    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;

    localparam logic [2:0] RM_DIRECT = 3'd6;

    localparam logic [2:0] SEG_ES = 3'd0;
    localparam logic [2:0] SEG_CS = 3'd1;
    localparam logic [2:0] SEG_SS = 3'd2;
    localparam logic [2:0] SEG_DS = 3'd3;
    localparam logic [2:0] SEG_FS = 3'd4;
    localparam logic [2:0] SEG_GS = 3'd5;

    typedef enum logic [4:0] {
        PH_PREFIX  = 5'b00001,
        PH_MODRM   = 5'b00010,
        PH_DISP8   = 5'b00100,
        PH_DISP_LO = 5'b01000,
        PH_DISP_HI = 5'b10000
    } phase_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  idx;
        logic [1:0]  width;
        logic [31:0] value;
    } rf_wr_t;

    typedef struct packed {
        logic [2:0] reg_idx;
        logic [2:0] rm_idx;
        logic [1:0] size;
    } rf_rd_req_t;

    typedef struct packed {
        logic [31:0] reg_val;
        logic [31:0] rm_val;
        logic [15:0] bx;
        logic [15:0] bp;
        logic [15:0] si;
        logic [15:0] di;
    } rf_rd_resp_t;

    // first field in the highest bits
    typedef struct packed {
        logic        prefix_overflow;
        logic [31:0] rm_register_value;
        logic [31:0] reg_operand;
        logic [15:0] effective_address;
        logic [2:0]  rm_field;
        logic [2:0]  reg_field;
        logic [1:0]  mod_field;
        logic [3:0]  prefix_flags;
        logic [2:0]  segment_select;
        logic [1:0]  operand_size;
        logic [8:0]  decoded_opcode;
    } result_t;

endpackage

// ===== src/x86pm_regfile.sv =====
// Eight 32-bit general registers with sized writes and sized reads.
// Depends on x86pm_pkg (write/read structs, size codes).
`timescale 1ns / 1ps

module x86pm_regfile (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  x86pm_pkg::rf_wr_t     wr,
    input  x86pm_pkg::rf_rd_req_t rd_req,
    output x86pm_pkg::rf_rd_resp_t rd_resp
);

    logic [31:0] rf_reg [x86pm_pkg::NUM_REGS];

    // 8-bit index 4..7 names bits 15:8 of entries 0..3
    function automatic logic [31:0] read_sized(input logic [31:0] rf [x86pm_pkg::NUM_REGS],
                                               input logic [2:0] idx,
                                               input logic [1:0] size);
        logic [31:0] r;
        r = 32'd0;
        case (size)
            x86pm_pkg::SZ_8: begin
                if (!idx[2]) r = {24'd0, rf[idx][7:0]};
                else         r = {24'd0, rf[{1'b0, idx[1:0]}][15:8]};
            end
            x86pm_pkg::SZ_16: r = {16'd0, rf[idx][15:0]};
            default:          r = rf[idx];
        endcase
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < x86pm_pkg::NUM_REGS; i++)
                rf_reg[i] <= (i == 0) ? 32'h0000_1234 : 32'd0;
        end else if (wr.en) begin
            case (wr.width)
                x86pm_pkg::SZ_8: begin
                    if (!wr.idx[2]) rf_reg[wr.idx][7:0] <= wr.value[7:0];
                    else            rf_reg[{1'b0, wr.idx[1:0]}][15:8] <= wr.value[7:0];
                end
                x86pm_pkg::SZ_16: rf_reg[wr.idx][15:0] <= wr.value[15:0];
                x86pm_pkg::SZ_32: rf_reg[wr.idx] <= wr.value;
                default: ;
            endcase
        end
    end

    assign rd_resp.reg_val = read_sized(rf_reg, rd_req.reg_idx, rd_req.size);
    assign rd_resp.rm_val  = read_sized(rf_reg, rd_req.rm_idx, rd_req.size);
    assign rd_resp.bx      = rf_reg[3][15:0];
    assign rd_resp.bp      = rf_reg[5][15:0];
    assign rd_resp.si      = rf_reg[6][15:0];
    assign rd_resp.di      = rf_reg[7][15:0];

endmodule

// ===== src/x86pm_decode.sv =====
// Per-instruction decode state and the one-byte step: prefixes, opcode, ModRM, disp.
// Depends on x86pm_pkg; reads register values through the register file ports.
`timescale 1ns / 1ps

module x86pm_decode (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic [7:0]             byte_in,
    input  logic [255:0]           modrm_map,
    input  x86pm_pkg::rf_rd_resp_t rd_resp,
    output x86pm_pkg::rf_rd_req_t  rd_req,
    output logic                   emit,
    output x86pm_pkg::result_t     result
);

    x86pm_pkg::phase_t              phase_reg, phase_next;
    logic [x86pm_pkg::PCNT_W-1:0]   cnt_reg, cnt_next;
    logic [2:0]                     seg_reg, seg_next;
    logic                           ovr_reg, ovr_next;
    logic [4:0]                     flags_reg, flags_next;
    logic [8:0]                     op_reg, op_next;
    logic                           ovf_reg, ovf_next;
    logic [7:0]                     modrm_reg, modrm_next;
    logic [7:0]                     dlo_reg, dlo_next;

    // working copies after this byte's prefix effect
    logic [x86pm_pkg::PCNT_W-1:0]   wk_cnt;
    logic [2:0]                     wk_seg;
    logic                           wk_ovr;
    logic [4:0]                     wk_flags;
    logic [8:0]                     wk_op;
    logic                           wk_ovf;
    logic                           is_prefix;
    logic                           op_done;
    logic                           has_modrm;

    logic                           em_with;
    logic [7:0]                     em_modrm;
    logic [15:0]                    em_disp;
    logic [1:0]                     em_mod;
    logic [2:0]                     em_rm;
    logic [1:0]                     em_size;
    logic [15:0]                    base;

    always_comb begin
        wk_cnt    = cnt_reg;
        wk_seg    = seg_reg;
        wk_ovr    = ovr_reg;
        wk_flags  = flags_reg;
        wk_op     = op_reg;
        wk_ovf    = ovf_reg;
        is_prefix = 1'b1;
        op_done   = 1'b0;
        em_with   = 1'b0;
        em_modrm  = modrm_reg;
        em_disp   = 16'd0;
        emit      = 1'b0;
        phase_next = phase_reg;
        modrm_next = modrm_reg;
        dlo_next   = dlo_reg;

        unique case (phase_reg)
            x86pm_pkg::PH_PREFIX: begin
                unique case (byte_in)
                    x86pm_pkg::PFX_ESC:   wk_op[8] = 1'b1;
                    x86pm_pkg::PFX_ES:    begin wk_ovr = 1'b1; wk_seg = x86pm_pkg::SEG_ES; end
                    x86pm_pkg::PFX_CS:    begin wk_ovr = 1'b1; wk_seg = x86pm_pkg::SEG_CS; end
                    x86pm_pkg::PFX_SS:    begin wk_ovr = 1'b1; wk_seg = x86pm_pkg::SEG_SS; end
                    x86pm_pkg::PFX_DS:    begin wk_ovr = 1'b1; wk_seg = x86pm_pkg::SEG_DS; end
                    x86pm_pkg::PFX_FS:    begin wk_ovr = 1'b1; wk_seg = x86pm_pkg::SEG_FS; end
                    x86pm_pkg::PFX_GS:    begin wk_ovr = 1'b1; wk_seg = x86pm_pkg::SEG_GS; end
                    x86pm_pkg::PFX_OPSZ:  wk_flags[x86pm_pkg::FLG_OPSZ] = ~flags_reg[x86pm_pkg::FLG_OPSZ];
                    x86pm_pkg::PFX_ADSZ:  wk_flags[x86pm_pkg::FLG_ADSZ] = ~flags_reg[x86pm_pkg::FLG_ADSZ];
                    x86pm_pkg::PFX_LOCK:  wk_flags[x86pm_pkg::FLG_LOCK]  = 1'b1;
                    x86pm_pkg::PFX_REPNE: wk_flags[x86pm_pkg::FLG_REPNE] = 1'b1;
                    x86pm_pkg::PFX_REP:   wk_flags[x86pm_pkg::FLG_REP]   = 1'b1;
                    default:              is_prefix = 1'b0;
                endcase
                wk_cnt = cnt_reg + 1'b1;
                if (!is_prefix) begin
                    wk_op   = {op_reg[8], byte_in};
                    op_done = 1'b1;
                end else if (wk_cnt >= x86pm_pkg::PCNT_W'(x86pm_pkg::MAX_PREFIXES)) begin
                    wk_ovf  = 1'b1;
                    op_done = 1'b1;
                end
            end
            x86pm_pkg::PH_MODRM: begin
                modrm_next = byte_in;
                em_modrm   = byte_in;
                if (flags_reg[x86pm_pkg::FLG_ADSZ] || byte_in[7:6] == x86pm_pkg::MOD_REG ||
                    (byte_in[7:6] == x86pm_pkg::MOD_NODISP && byte_in[2:0] != x86pm_pkg::RM_DIRECT)) begin
                    emit    = 1'b1;
                    em_with = 1'b1;
                end else if (byte_in[7:6] == x86pm_pkg::MOD_DISP8) begin
                    phase_next = x86pm_pkg::PH_DISP8;
                end else begin
                    phase_next = x86pm_pkg::PH_DISP_LO;
                end
            end
            x86pm_pkg::PH_DISP8: begin
                emit    = 1'b1;
                em_with = 1'b1;
                em_disp = {{8{byte_in[7]}}, byte_in};
            end
            x86pm_pkg::PH_DISP_LO: begin
                dlo_next   = byte_in;
                phase_next = x86pm_pkg::PH_DISP_HI;
            end
            x86pm_pkg::PH_DISP_HI: begin
                emit    = 1'b1;
                em_with = 1'b1;
                em_disp = {byte_in, dlo_reg};
            end
            default: phase_next = x86pm_pkg::PH_PREFIX;
        endcase

        // escape opcodes never carry ModRM
        has_modrm = !wk_op[8] && modrm_map[wk_op[7:0]];
        if (op_done) begin
            if (has_modrm) phase_next = x86pm_pkg::PH_MODRM;
            else           emit = 1'b1;
        end

        if (emit) begin
            phase_next = x86pm_pkg::PH_PREFIX;
            cnt_next   = '0;
            seg_next   = x86pm_pkg::SEG_DS;
            ovr_next   = 1'b0;
            flags_next = 5'd0;
            op_next    = 9'd0;
            ovf_next   = 1'b0;
        end else begin
            cnt_next   = wk_cnt;
            seg_next   = wk_seg;
            ovr_next   = wk_ovr;
            flags_next = wk_flags;
            op_next    = wk_op;
            ovf_next   = wk_ovf;
        end
    end

    assign em_mod  = em_modrm[7:6];
    assign em_rm   = em_modrm[2:0];
    assign em_size = !wk_op[0] ? x86pm_pkg::SZ_8 :
                     (wk_flags[x86pm_pkg::FLG_OPSZ] ? x86pm_pkg::SZ_32 : x86pm_pkg::SZ_16);

    assign rd_req.reg_idx = em_modrm[5:3];
    assign rd_req.rm_idx  = em_rm;
    assign rd_req.size    = em_size;

    always_comb begin
        case (em_rm)
            3'd0:    base = rd_resp.bx + rd_resp.si;
            3'd1:    base = rd_resp.bx + rd_resp.di;
            3'd2:    base = rd_resp.bp + rd_resp.si;
            3'd3:    base = rd_resp.bp + rd_resp.di;
            3'd4:    base = rd_resp.si;
            3'd5:    base = rd_resp.di;
            3'd6:    base = rd_resp.bp;
            default: base = rd_resp.bx;
        endcase
    end

    always_comb begin
        result.decoded_opcode    = wk_op;
        result.operand_size      = em_size;
        result.prefix_flags      = wk_flags[3:0];
        result.prefix_overflow   = wk_ovf;
        result.segment_select    = wk_seg;
        result.mod_field         = 2'd0;
        result.reg_field         = 3'd0;
        result.rm_field          = 3'd0;
        result.effective_address = 16'd0;
        result.reg_operand       = 32'd0;
        result.rm_register_value = 32'd0;
        if (em_with) begin
            result.mod_field   = em_mod;
            result.reg_field   = em_modrm[5:3];
            result.rm_field    = em_rm;
            result.reg_operand = rd_resp.reg_val;
            // BP-based forms default to the stack segment
            if (!wk_ovr &&
                (((em_mod == x86pm_pkg::MOD_DISP8 || em_mod == x86pm_pkg::MOD_DISP16) &&
                  (em_rm == 3'd2 || em_rm == 3'd3 || em_rm == 3'd6)) ||
                 (em_mod == x86pm_pkg::MOD_NODISP && (em_rm == 3'd2 || em_rm == 3'd3))))
                result.segment_select = x86pm_pkg::SEG_SS;
            if (em_mod == x86pm_pkg::MOD_REG) begin
                result.rm_register_value = rd_resp.rm_val;
            end else if (!wk_flags[x86pm_pkg::FLG_ADSZ]) begin
                if (em_mod == x86pm_pkg::MOD_NODISP && em_rm == x86pm_pkg::RM_DIRECT)
                    result.effective_address = em_disp;
                else
                    result.effective_address = base + em_disp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= x86pm_pkg::PH_PREFIX;
            cnt_reg   <= '0;
            seg_reg   <= x86pm_pkg::SEG_DS;
            ovr_reg   <= 1'b0;
            flags_reg <= 5'd0;
            op_reg    <= 9'd0;
            ovf_reg   <= 1'b0;
            modrm_reg <= 8'd0;
            dlo_reg   <= 8'd0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            seg_reg   <= seg_next;
            ovr_reg   <= ovr_next;
            flags_reg <= flags_next;
            op_reg    <= op_next;
            ovf_reg   <= ovf_next;
            modrm_reg <= modrm_next;
            dlo_reg   <= dlo_next;
        end
    end

endmodule

// ===== src/x86_prefix_modrm_decoder_core.sv =====
// Top level: input item register, ModRM map registers, decode step and result register.
// Depends on x86pm_pkg, x86pm_regfile and x86pm_decode.
//
//  channel   dir  handshake         payload
//  s_        in   s_tvalid/tready   tuser: kind; tdata: byte, reg index/width, value
//  m_        out  m_tvalid/tready   tdata: one decoded instruction
//  cfg_      in   cfg_wr_en         cfg_addr selects map word, cfg_wdata
//
// One item per cycle while the m_ side is not stalled: an accepted item is held in the input register,
// and its result (if any) is registered into the result register when the item advances.
// aresetn (synchronous) clears decode state and the ModRM map, and resets the register file (entry 0 to 0x1234).
// A stalled m_ side holds the input register; s_tready drops only when both are full.
`timescale 1ns / 1ps

module x86_prefix_modrm_decoder_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tuser,   // [0] kind: byte or register write
    input  logic [47:0]   s_tdata,   // byte_in[7:0], reg_index[10:8], reg_width[12:11],
                                     // write_value[44:13], zero fill
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // decoded_opcode, operand_size, segment_select,
                                     // prefix_flags, mod, reg, rm, effective_address,
                                     // reg_operand, rm_register_value, prefix_overflow
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_addr,
    input  logic [63:0]   cfg_wdata
);

    logic                      in_valid_reg;
    logic                      in_kind_reg;
    logic [44:0]               in_data_reg;
    logic                      advance;
    logic                      m_valid_reg;
    x86pm_pkg::result_t        m_data_reg;
    logic [x86pm_pkg::MAP_W-1:0] map_reg [x86pm_pkg::NUM_MAPS];

    x86pm_pkg::rf_wr_t         rf_wr;
    x86pm_pkg::rf_rd_req_t     rd_req;
    x86pm_pkg::rf_rd_resp_t    rd_resp;
    logic                      emit;
    x86pm_pkg::result_t        result;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata[44:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < x86pm_pkg::NUM_MAPS; i++) map_reg[i] <= '0;
        end else if (cfg_wr_en) begin
            map_reg[cfg_addr] <= cfg_wdata;
        end
    end

    assign rf_wr.en    = advance && (in_kind_reg == x86pm_pkg::KIND_REGWR);
    assign rf_wr.idx   = in_data_reg[10:8];
    assign rf_wr.width = in_data_reg[12:11];
    assign rf_wr.value = in_data_reg[44:13];

    x86pm_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (rf_wr),
        .rd_req  (rd_req),
        .rd_resp (rd_resp)
    );

    x86pm_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance && (in_kind_reg == x86pm_pkg::KIND_BYTE)),
        .byte_in   (in_data_reg[7:0]),
        .modrm_map ({map_reg[3], map_reg[2], map_reg[1], map_reg[0]}),
        .rd_resp   (rd_resp),
        .rd_req    (rd_req),
        .emit      (emit),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit && (in_kind_reg == x86pm_pkg::KIND_BYTE)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit && (in_kind_reg == x86pm_pkg::KIND_BYTE))
            m_data_reg <= result;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

    // backpressure only when both stages hold an item and the sink stalls
    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_valid_reg && !m_tready))
        else $error("s_tready low without a full pipe");

    a_size_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.operand_size != 2'd3))
        else $error("bad operand size code");

    a_segment_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.segment_select <= x86pm_pkg::SEG_GS))
        else $error("bad segment code");

    a_overflow_opcode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.prefix_overflow) |-> (m_data_reg.decoded_opcode[7:0] == 8'd0))
        else $error("prefix overflow with opcode bits set");

endmodule

// ===== tb/sv/tb_x86_prefix_modrm_decoder_core.sv =====
// Self-checking bench for x86_prefix_modrm_decoder_core: a scripted opening, then random
// byte streams and register writes over several ModRM map settings, checked by a decode model.
// Depends on x86pm_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_x86_prefix_modrm_decoder_core;
    import x86pm_pkg::*;

    localparam int HANG_LIMIT  = 600;
    localparam int PHASE_ITEMS = 360;
    localparam int NUM_PHASES  = 5;

    // x86 register numbers used in 16-bit addressing
    localparam logic [2:0] REG_BX = 3'd3;
    localparam logic [2:0] REG_BP = 3'd5;
    localparam logic [2:0] REG_SI = 3'd6;
    localparam logic [2:0] REG_DI = 3'd7;

    // r/m encodings for memory forms
    localparam logic [2:0] RM_BX_SI = 3'd0;
    localparam logic [2:0] RM_BX_DI = 3'd1;
    localparam logic [2:0] RM_BP_SI = 3'd2;
    localparam logic [2:0] RM_BP_DI = 3'd3;
    localparam logic [2:0] RM_SI    = 3'd4;
    localparam logic [2:0] RM_DI    = 3'd5;
    localparam logic [2:0] RM_BP    = 3'd6;

    typedef enum int {ROW_ITEM, ROW_MAP} row_act_t;

    typedef struct {
        row_act_t    act;
        logic        kind;
        logic [47:0] data;      // item payload; map index in [1:0] for ROW_MAP
        logic [63:0] map_val;
        logic        typed;
        result_t     want;
    } stim_row_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic          s_tuser;
    logic [47:0]   s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [111:0]  m_tdata;
    logic          cfg_wr_en;
    logic [1:0]    cfg_addr;
    logic [63:0]   cfg_wdata;

    // decode model state
    logic [63:0]   map_q [NUM_MAPS];
    logic [31:0]   gpr [NUM_REGS];
    phase_t        dphase;
    int            pcount;
    logic [2:0]    seg_q;
    logic          ovr_q;
    logic [4:0]    mflags;
    logic [8:0]    op_q;
    logic [7:0]    modrm_q;
    logic [7:0]    dlo_q;
    logic          ovf_q;

    result_t       pending_insns [$];
    stim_row_t     script [$];
    logic [7:0]    prefix_bytes [12];
    int            errs;
    int            idle_cycles;
    bit            no_idle;
    int unsigned   pfx_pct;
    result_t       got_r;
    result_t       want_r;

    x86_prefix_modrm_decoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [47:0] tdata_of(logic [7:0] b, logic [2:0] idx, logic [1:0] w,
                                             logic [31:0] v);
        return {3'b000, v, w, idx, b};
    endfunction

    function automatic logic [31:0] gpr_read(logic [2:0] idx, logic [1:0] size);
        if (size == SZ_8)
            return idx[2] ? {24'h0, gpr[idx[1:0]][15:8]} : {24'h0, gpr[idx[1:0]][7:0]};
        if (size == SZ_16)
            return {16'h0, gpr[idx][15:0]};
        return gpr[idx];
    endfunction

    function automatic void gpr_write(logic [2:0] idx, logic [1:0] w, logic [31:0] v);
        case (w)
            SZ_8: begin
                // AH..BH live in bits 15:8 of AX..BX
                if (idx[2])
                    gpr[idx[1:0]][15:8] = v[7:0];
                else
                    gpr[idx[1:0]][7:0] = v[7:0];
            end
            SZ_16: gpr[idx][15:0] = v[15:0];
            SZ_32: gpr[idx] = v;
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] ea_base(logic [2:0] rm);
        logic [15:0] bx, bp, si, di;
        bx = gpr[REG_BX][15:0];
        bp = gpr[REG_BP][15:0];
        si = gpr[REG_SI][15:0];
        di = gpr[REG_DI][15:0];
        case (rm)
            RM_BX_SI: return bx + si;
            RM_BX_DI: return bx + di;
            RM_BP_SI: return bp + si;
            RM_BP_DI: return bp + di;
            RM_SI:    return si;
            RM_DI:    return di;
            RM_BP:    return bp;
            default:  return bx;
        endcase
    endfunction

    function automatic void clear_insn();
        dphase = PH_PREFIX;
        pcount = 0;
        seg_q  = SEG_DS;
        ovr_q  = 1'b0;
        mflags = '0;
        op_q   = '0;
        ovf_q  = 1'b0;
    endfunction

    function automatic void retire_insn(logic with_modrm, logic [15:0] disp);
        result_t    r;
        logic [1:0] md;
        logic [2:0] rm;
        r = '0;
        r.decoded_opcode  = op_q;
        r.operand_size    = !op_q[0] ? SZ_8 : (mflags[FLG_OPSZ] ? SZ_32 : SZ_16);
        r.segment_select  = seg_q;
        r.prefix_flags    = mflags[3:0];
        r.prefix_overflow = ovf_q;
        if (with_modrm) begin
            md = modrm_q[7:6];
            rm = modrm_q[2:0];
            r.mod_field = md;
            r.reg_field = modrm_q[5:3];
            r.rm_field  = rm;
            // BP-based forms default to SS
            if (!ovr_q && (((md == MOD_DISP8 || md == MOD_DISP16) &&
                            (rm == RM_BP_SI || rm == RM_BP_DI || rm == RM_BP)) ||
                           (md == MOD_NODISP && (rm == RM_BP_SI || rm == RM_BP_DI))))
                r.segment_select = SEG_SS;
            r.reg_operand = gpr_read(modrm_q[5:3], r.operand_size);
            if (md == MOD_REG)
                r.rm_register_value = gpr_read(rm, r.operand_size);
            else if (!mflags[FLG_ADSZ])
                r.effective_address = (md == MOD_NODISP && rm == RM_DIRECT) ?
                                      disp : ea_base(rm) + disp;
        end
        pending_insns.push_back(r);
        clear_insn();
    endfunction

    function automatic void opcode_settled();
        if (!op_q[8] && map_q[op_q[7:6]][op_q[5:0]])
            dphase = PH_MODRM;
        else
            retire_insn(1'b0, 16'h0);
    endfunction

    function automatic void decode_step(logic kind, logic [47:0] d);
        logic [7:0] b;
        logic       is_pfx;
        b = d[7:0];
        if (kind == KIND_REGWR) begin
            gpr_write(d[10:8], d[12:11], d[44:13]);
            return;
        end
        case (dphase)
            PH_MODRM: begin
                modrm_q = b;
                if (mflags[FLG_ADSZ] || b[7:6] == MOD_REG ||
                    (b[7:6] == MOD_NODISP && b[2:0] != RM_DIRECT))
                    retire_insn(1'b1, 16'h0);
                else
                    dphase = (b[7:6] == MOD_DISP8) ? PH_DISP8 : PH_DISP_LO;
            end
            PH_DISP8:   retire_insn(1'b1, {{8{b[7]}}, b});
            PH_DISP_LO: begin
                dlo_q  = b;
                dphase = PH_DISP_HI;
            end
            PH_DISP_HI: retire_insn(1'b1, {b, dlo_q});
            default: begin
                is_pfx = 1'b1;
                case (b)
                    PFX_ESC:   op_q[8] = 1'b1;
                    PFX_ES:    begin ovr_q = 1'b1; seg_q = SEG_ES; end
                    PFX_CS:    begin ovr_q = 1'b1; seg_q = SEG_CS; end
                    PFX_SS:    begin ovr_q = 1'b1; seg_q = SEG_SS; end
                    PFX_DS:    begin ovr_q = 1'b1; seg_q = SEG_DS; end
                    PFX_FS:    begin ovr_q = 1'b1; seg_q = SEG_FS; end
                    PFX_GS:    begin ovr_q = 1'b1; seg_q = SEG_GS; end
                    PFX_OPSZ:  mflags[FLG_OPSZ] = ~mflags[FLG_OPSZ];
                    PFX_ADSZ:  mflags[FLG_ADSZ] = ~mflags[FLG_ADSZ];
                    PFX_LOCK:  mflags[FLG_LOCK] = 1'b1;
                    PFX_REPNE: mflags[FLG_REPNE] = 1'b1;
                    PFX_REP:   mflags[FLG_REP] = 1'b1;
                    default:   is_pfx = 1'b0;
                endcase
                pcount++;
                if (!is_pfx) begin
                    op_q = {op_q[8], b};
                    opcode_settled();
                end else if (pcount >= MAX_PREFIXES) begin
                    ovf_q = 1'b1;
                    opcode_settled();
                end
            end
        endcase
    endfunction

    function automatic result_t expect_plain(logic [8:0] op, logic [1:0] size, logic [2:0] seg,
                                             logic [3:0] flags, logic ovf);
        result_t r;
        r = '0;
        r.decoded_opcode  = op;
        r.operand_size    = size;
        r.segment_select  = seg;
        r.prefix_flags    = flags;
        r.prefix_overflow = ovf;
        return r;
    endfunction

    function automatic stim_row_t byte_row(logic [7:0] b);
        stim_row_t r;
        r = '{ROW_ITEM, KIND_BYTE, tdata_of(b, 3'd0, SZ_8, 32'h0), 64'h0, 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t fixed_row(logic [7:0] b, result_t want);
        stim_row_t r;
        r = byte_row(b);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic stim_row_t regwr_row(logic [2:0] idx, logic [1:0] w, logic [31:0] v);
        stim_row_t r;
        r = '{ROW_ITEM, KIND_REGWR, tdata_of(8'h00, idx, w, v), 64'h0, 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t map_row(logic [1:0] idx, logic [63:0] v);
        stim_row_t r;
        r = '{ROW_MAP, KIND_BYTE, {46'h0, idx}, v, 1'b0, '0};
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errs++;
        end
    endfunction

    // one item over the input stream; the model steps when the handshake completes
    task automatic push_item(input logic kind, input logic [47:0] d);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = d;
        do @(posedge aclk); while (!s_tready);
        decode_step(kind, d);
    endtask

    // hold off the sender until every decoded instruction is out and the pipe is empty
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_insns.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_map(input logic [1:0] idx, input logic [63:0] v);
        wait_idle();
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = v;
        map_q[idx] = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic random_item();
        logic [47:0] d;
        d = tdata_of(8'($urandom), 3'($urandom), 2'($urandom), $urandom);
        if ($urandom_range(0, 99) < 12) begin
            push_item(KIND_REGWR, d);
        end else begin
            // some instructions start a long prefix run to reach the overflow case
            if (dphase == PH_PREFIX && pcount == 0)
                pfx_pct = ($urandom_range(0, 99) < 6) ? 92 : 30;
            if (dphase == PH_PREFIX && $urandom_range(0, 99) < pfx_pct)
                d[7:0] = prefix_bytes[$urandom_range(0, 11)];
            push_item(KIND_BYTE, d);
        end
    endtask

    // result side: random stall before each item
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : $urandom_range(0, 18);
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_insns.size() == 0) begin
                $error("result item with no instruction pending: 0x%0h", m_tdata);
                errs++;
            end else begin
                want_r = pending_insns.pop_front();
                got_r  = result_t'(m_tdata[$bits(result_t)-1:0]);
                check_field("decoded_opcode", 32'(want_r.decoded_opcode),
                            32'(got_r.decoded_opcode));
                check_field("operand_size", 32'(want_r.operand_size),
                            32'(got_r.operand_size));
                check_field("segment_select", 32'(want_r.segment_select),
                            32'(got_r.segment_select));
                check_field("prefix_flags", 32'(want_r.prefix_flags),
                            32'(got_r.prefix_flags));
                check_field("mod_field", 32'(want_r.mod_field), 32'(got_r.mod_field));
                check_field("reg_field", 32'(want_r.reg_field), 32'(got_r.reg_field));
                check_field("rm_field", 32'(want_r.rm_field), 32'(got_r.rm_field));
                check_field("effective_address", 32'(want_r.effective_address),
                            32'(got_r.effective_address));
                check_field("reg_operand", want_r.reg_operand, got_r.reg_operand);
                check_field("rm_register_value", want_r.rm_register_value,
                            got_r.rm_register_value);
                check_field("prefix_overflow", 32'(want_r.prefix_overflow),
                            32'(got_r.prefix_overflow));
            end
        end
    end

    // watchdog: too long with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("x86_prefix_modrm_decoder_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = KIND_BYTE;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        no_idle     = 1'b0;
        pfx_pct     = 30;
        prefix_bytes = '{PFX_ESC, PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
                         PFX_OPSZ, PFX_ADSZ, PFX_LOCK, PFX_REPNE, PFX_REP};
        for (int i = 0; i < NUM_MAPS; i++)
            map_q[i] = '0;
        for (int i = 0; i < NUM_REGS; i++)
            gpr[i] = '0;
        gpr[0]  = 32'h1234;
        modrm_q = '0;
        dlo_q   = '0;
        clear_insn();

        // map is all clear out of reset, so nothing takes a ModRM byte yet
        script.push_back(byte_row(PFX_OPSZ));
        script.push_back(fixed_row(8'hFF, expect_plain(9'h0FF, SZ_32, SEG_DS, 4'h0, 1'b0)));
        // six prefixes with no opcode: escape bit alone, every flag set
        script.push_back(byte_row(PFX_LOCK));
        script.push_back(byte_row(PFX_REPNE));
        script.push_back(byte_row(PFX_REP));
        script.push_back(byte_row(PFX_ADSZ));
        script.push_back(byte_row(PFX_ES));
        script.push_back(fixed_row(PFX_ESC, expect_plain(9'h100, SZ_8, SEG_ES, 4'hF, 1'b1)));
        script.push_back(regwr_row(REG_DI, SZ_32, 32'hFFFF_FFFF));
        script.push_back(regwr_row(3'd4, SZ_8, 32'h0000_00AB));   // AH
        script.push_back(map_row(2'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        script.push_back(map_row(2'd1, 64'h0));
        script.push_back(map_row(2'd2, 64'h5555_5555_5555_5555));
        script.push_back(map_row(2'd3, 64'hFFFF_FFFF_FFFF_FFFF));
        // register form, AX against DI
        script.push_back(byte_row(8'h01));
        script.push_back(byte_row(8'hC7));
        // ES override on a BP form with a negative disp8
        script.push_back(byte_row(PFX_ES));
        script.push_back(byte_row(8'h03));
        script.push_back(byte_row(8'h46));
        script.push_back(byte_row(8'h80));
        // BP + disp16, defaults to SS
        script.push_back(byte_row(8'h03));
        script.push_back(byte_row(8'h86));
        script.push_back(byte_row(8'h34));
        script.push_back(byte_row(8'h12));
        // direct address at the top of the segment
        script.push_back(byte_row(8'h00));
        script.push_back(byte_row(8'h06));
        script.push_back(byte_row(8'hFF));
        script.push_back(byte_row(8'hFF));
        // address-size toggle: no displacement follows
        script.push_back(byte_row(PFX_ADSZ));
        script.push_back(byte_row(8'h01));
        script.push_back(byte_row(8'h86));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (script[i]) begin
            if (script[i].act == ROW_MAP) begin
                write_map(script[i].data[1:0], script[i].map_val);
            end else begin
                push_item(script[i].kind, script[i].data);
                // hand-written expectation takes the place of the modeled one
                if (script[i].typed)
                    pending_insns[$] = script[i].want;
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int m = 0; m < NUM_MAPS; m++) begin
                case (p)
                    0:       write_map(2'(m), 64'hFFFF_FFFF_FFFF_FFFF);
                    1:       write_map(2'(m), 64'h0);
                    default: write_map(2'(m), {$urandom, $urandom});
                endcase
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 90 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 149) == 0)
                    wait_idle();
                random_item();
            end
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (errs == 0)
            $display("x86_prefix_modrm_decoder_core verification clean");
        else
            $display("x86_prefix_modrm_decoder_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/x86pm_pkg.sv
src/x86pm_regfile.sv
src/x86pm_decode.sv
src/x86_prefix_modrm_decoder_core.sv
tb/sv/tb_x86_prefix_modrm_decoder_core.sv
